[rtl/nlqt_pkg.sv]
// Shared constants, types and state codes of the neighbour link quality table.
package nlqt_pkg;

   localparam int ADDR_W            = 16;
   localparam int SAMPLE_W          = 8;
   localparam int SEQ_W             = 8;
   localparam int SLOT_W            = 6;
   localparam int COUNT_W           = 16;
   localparam int DEF_TABLE_ENTRIES = 40;
   localparam int QUOT_W            = 9;
   localparam int DIV_STEPS         = QUOT_W;
   localparam int STEP_W            = 4;
   localparam int DIVIDEND_W        = 24;
   localparam int PROD_W            = COUNT_W + SAMPLE_W + 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MUL_RSSI,
      S_DIV_RSSI,
      S_MUL_LQI,
      S_DIV_LQI,
      S_DONE
   } nlqt_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic [ADDR_W-1:0]          addr;
      logic [COUNT_W-1:0]         count;
      logic signed [SAMPLE_W-1:0] mean_rssi;
      logic [SAMPLE_W-1:0]        mean_lqi;
      logic [SEQ_W-1:0]           last_seq;
   } entry_type;

endpackage

[rtl/nlqt_req_if.sv]
// Packet channel into the neighbour link quality table.
interface nlqt_req_if;
   import nlqt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ADDR_W-1:0]          src_addr;
   logic signed [SAMPLE_W-1:0] rssi;
   logic [SAMPLE_W-1:0]        lqi;
   logic [SEQ_W-1:0]           seq_num;

   modport source (output valid, output src_addr, output rssi, output lqi, output seq_num,
                   input ready);
   modport sink (input valid, input src_addr, input rssi, input lqi, input seq_num,
                 output ready);
endinterface

[rtl/nlqt_rsp_if.sv]
// Result channel out of the neighbour link quality table.
interface nlqt_rsp_if;
   import nlqt_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [SLOT_W-1:0]          slot;
   logic                       is_new;
   logic                       dropped;
   logic [COUNT_W-1:0]         pkt_count;
   logic signed [SAMPLE_W-1:0] mean_rssi;
   logic [SAMPLE_W-1:0]        mean_lqi;

   modport source (output valid, output slot, output is_new, output dropped,
                   output pkt_count, output mean_rssi, output mean_lqi, input ready);
   modport sink (input valid, input slot, input is_new, input dropped,
                 input pkt_count, input mean_rssi, input mean_lqi, output ready);
endinterface

[rtl/nlqt_div.sv]
// Iterative restoring divider producing one quotient bit per cycle.
module nlqt_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [nlqt_pkg::DIVIDEND_W-1:0]       dividend,
   input  logic [nlqt_pkg::COUNT_W-1:0]          divisor,
   output nlqt_pkg::div_status_type              status,
   output logic [nlqt_pkg::QUOT_W-1:0]           quotient
);
   import nlqt_pkg::*;

   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]  dq_ff, dq_in;
   logic [COUNT_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;
   logic               ge;

   // The quotient is known to fit in QUOT_W bits, so the upper dividend bits start as the
   // partial remainder.
   always_comb begin
      trial   = {rem_ff, dq_ff[QUOT_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = COUNT_W'(dividend >> QUOT_W);
         dq_in   = dividend[QUOT_W-1:0];
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         dq_in   = {dq_ff[QUOT_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dq_ff;

endmodule

[rtl/neighbor_link_quality_table.sv]
// Top level of the neighbour link quality table: scan sequencer, entry memory and mean update.
//
//   Channel   Direction  Contents
//   req_if    in         src_addr, rssi, lqi, seq_num
//   rsp_if    out        slot, is_new, dropped, pkt_count, mean_rssi, mean_lqi
//
// A packet is scanned against one table entry per cycle through the memory read port; a new
// neighbour or a dropped packet is scanned through the whole table, while a hit ends the scan
// at its entry, and the two means then share one multiplier and one nine-step divider.
// Reset clears the valid bits at once; the entry memory itself is not cleared.
// A finished result waits in the output register while the next packet is taken in.
module neighbor_link_quality_table #(
   parameter int TABLE_ENTRIES = nlqt_pkg::DEF_TABLE_ENTRIES
) (
   input logic        clock,
   input logic        reset,
   nlqt_req_if.sink   req_if,
   nlqt_rsp_if.source rsp_if
);
   import nlqt_pkg::*;

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   entry_type table_mem [TABLE_ENTRIES];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;

   nlqt_state_type state_ff, state_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic signed [SAMPLE_W-1:0] rssi_ff, rssi_in;
   logic [SAMPLE_W-1:0]        lqi_ff, lqi_in;
   logic [SEQ_W-1:0]           seq_ff, seq_in;
   logic [IDX_W-1:0]           scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic                       hit_ff, hit_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic                       free_ff, free_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0]         n_ff, n_in;
   logic signed [SAMPLE_W-1:0] mean_rssi_ff, mean_rssi_in;
   logic [SAMPLE_W-1:0]        mean_lqi_ff, mean_lqi_in;
   logic                       neg_ff, neg_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic                       rsp_new_ff, rsp_new_in;
   logic                       rsp_drop_ff, rsp_drop_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic signed [SAMPLE_W-1:0] rsp_rssi_ff, rsp_rssi_in;
   logic [SAMPLE_W-1:0]        rsp_lqi_ff, rsp_lqi_in;

   logic signed [COUNT_W:0]    op_a;
   logic signed [SAMPLE_W:0]   op_b;
   logic signed [SAMPLE_W:0]   addend;
   logic signed [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]          prod_mag;
   logic                       div_start;
   div_status_type             div_stat;
   logic [QUOT_W-1:0]          div_quot;
   logic [QUOT_W-1:0]          quot_signed;
   logic                       entry_v;
   logic                       out_free;
   logic [WIDE_W-1:0]          slot_wide;

   nlqt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag[DIVIDEND_W-1:0]),
      .divisor  (n_ff),
      .status   (div_stat),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= table_mem[scan_idx_ff];
   end

   always_comb begin
      op_a = $signed({1'b0, n_ff - COUNT_W'(1)});
      if (state_ff == S_MUL_LQI) begin
         op_b   = $signed({1'b0, mean_lqi_ff});
         addend = $signed({1'b0, lqi_ff});
      end else begin
         op_b   = {mean_rssi_ff[SAMPLE_W-1], mean_rssi_ff};
         addend = {rssi_ff[SAMPLE_W-1], rssi_ff};
      end
      prod        = PROD_W'(op_a * op_b) + PROD_W'(addend);
      prod_mag    = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
      quot_signed = neg_ff ? (QUOT_W'(0) - div_quot) : div_quot;
      entry_v     = valid_ff[cmp_idx_ff];
      out_free    = !rsp_valid_ff || rsp_if.ready;
      slot_wide   = WIDE_W'(hit_ff ? hit_idx_ff : free_idx_ff);
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      addr_in      = addr_ff;
      rssi_in      = rssi_ff;
      lqi_in       = lqi_ff;
      seq_in       = seq_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      n_in         = n_ff;
      mean_rssi_in = mean_rssi_ff;
      mean_lqi_in  = mean_lqi_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rssi_in  = rsp_rssi_ff;
      rsp_lqi_in   = rsp_lqi_ff;
      div_start    = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = hit_ff ? hit_idx_ff : free_idx_ff;
      wr_data      = '{addr: addr_ff, count: n_ff, mean_rssi: mean_rssi_ff,
                       mean_lqi: mean_lqi_ff, last_seq: seq_ff};
      req_if.ready = (state_ff == S_IDLE);

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               addr_in     = req_if.src_addr;
               rssi_in     = req_if.rssi;
               lqi_in      = req_if.lqi;
               seq_in      = req_if.seq_num;
               scan_idx_in = '0;
               cmp_vld_in  = 1'b0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = scan_idx_ff;
            if (scan_idx_ff != LAST_IDX) begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
            if (cmp_vld_ff) begin
               if (!entry_v && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (entry_v && rd_data_ff.addr == addr_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = cmp_idx_ff;
                  n_in         = (rd_data_ff.count == COUNT_MAX) ? rd_data_ff.count
                                 : rd_data_ff.count + COUNT_W'(1);
                  mean_rssi_in = rd_data_ff.mean_rssi;
                  mean_lqi_in  = rd_data_ff.mean_lqi;
                  state_in     = S_MUL_RSSI;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end
         S_MUL_RSSI: begin
            div_start = 1'b1;
            neg_in    = prod[PROD_W-1];
            state_in  = S_DIV_RSSI;
         end
         S_DIV_RSSI: begin
            if (div_stat.done) begin
               mean_rssi_in = quot_signed[SAMPLE_W-1:0];
               state_in     = S_MUL_LQI;
            end
         end
         S_MUL_LQI: begin
            div_start = 1'b1;
            state_in  = S_DIV_LQI;
         end
         S_DIV_LQI: begin
            if (div_stat.done) begin
               mean_lqi_in = div_quot[SAMPLE_W-1:0];
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = slot_wide[SLOT_W-1:0];
               rsp_new_in   = 1'b0;
               rsp_drop_in  = 1'b0;
               priority if (hit_ff) begin
                  wr_en        = 1'b1;
                  rsp_count_in = n_ff;
                  rsp_rssi_in  = mean_rssi_ff;
                  rsp_lqi_in   = mean_lqi_ff;
               end else if (free_ff) begin
                  wr_en                 = 1'b1;
                  wr_data               = '{addr: addr_ff, count: COUNT_W'(1),
                                            mean_rssi: rssi_ff, mean_lqi: lqi_ff,
                                            last_seq: seq_ff};
                  valid_in[free_idx_ff] = 1'b1;
                  rsp_new_in            = 1'b1;
                  rsp_count_in          = COUNT_W'(1);
                  rsp_rssi_in           = rssi_ff;
                  rsp_lqi_in            = lqi_ff;
               end else begin
                  rsp_slot_in  = '0;
                  rsp_drop_in  = 1'b1;
                  rsp_count_in = '0;
                  rsp_rssi_in  = '0;
                  rsp_lqi_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      rssi_ff      <= rssi_in;
      lqi_ff       <= lqi_in;
      seq_ff       <= seq_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmp_vld_ff   <= cmp_vld_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      n_ff         <= n_in;
      mean_rssi_ff <= mean_rssi_in;
      mean_lqi_ff  <= mean_lqi_in;
      neg_ff       <= neg_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rssi_ff  <= rsp_rssi_in;
      rsp_lqi_ff   <= rsp_lqi_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.slot      = rsp_slot_ff;
   assign rsp_if.is_new    = rsp_new_ff;
   assign rsp_if.dropped   = rsp_drop_ff;
   assign rsp_if.pkt_count = rsp_count_ff;
   assign rsp_if.mean_rssi = rsp_rssi_ff;
   assign rsp_if.mean_lqi  = rsp_lqi_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("Divider started while a division was still running.");

   a_new_entry_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free && !hit_ff && free_ff) |=> valid_ff[$past(free_idx_ff)])
      else $error("A newly created entry was not marked valid.");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_drop_ff) |-> (rsp_count_ff != '0))
      else $error("A result that was not dropped carries a zero packet count.");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the neighbour link quality table: lookup, means, long runs, full table.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import nlqt_pkg::*;

   localparam int ENTRIES      = DEF_TABLE_ENTRIES;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 6_000_000;

   typedef struct packed {
      logic [SLOT_W-1:0]          slot;
      logic                       is_new;
      logic                       dropped;
      logic [COUNT_W-1:0]         pkt_count;
      logic signed [SAMPLE_W-1:0] mean_rssi;
      logic [SAMPLE_W-1:0]        mean_lqi;
   } link_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nlqt_req_if req_bus ();
   nlqt_rsp_if rsp_bus ();

   neighbor_link_quality_table #(
      .TABLE_ENTRIES(ENTRIES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   // Predicted neighbour table.
   logic                       nb_valid [ENTRIES];
   logic [ADDR_W-1:0]          nb_addr  [ENTRIES];
   logic [COUNT_W-1:0]         nb_count [ENTRIES];
   logic signed [SAMPLE_W-1:0] nb_rssi  [ENTRIES];
   logic [SAMPLE_W-1:0]        nb_lqi   [ENTRIES];
   logic [SEQ_W-1:0]           nb_seq   [ENTRIES];

   link_result_type expected_results[$];

   int  mismatches       = 0;
   int  results_checked  = 0;
   int  packets_sent     = 0;
   int  entries_used     = 0;
   int  update_count     = 0;
   int  saturated_count  = 0;
   int  drop_count       = 0;
   int  cycle_count      = 0;
   int  burst_left       = 0;
   bit  sender_idle      = 1'b0;
   bit  receiver_idle    = 1'b0;
   logic [15:0] stall_word  = '1;
   int          stall_phase = 0;

   always #6 clock = ~clock;

   function automatic link_result_type predict_packet(input logic [ADDR_W-1:0] addr,
                                                      input logic signed [SAMPLE_W-1:0] rssi,
                                                      input logic [SAMPLE_W-1:0] lqi,
                                                      input logic [SEQ_W-1:0] seq);
      link_result_type res;
      int hit;
      int free_slot;
      int n;
      int mean_r;
      int mean_q;
      res       = '0;
      hit       = -1;
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (nb_valid[i]) begin
            if (hit < 0 && nb_addr[i] == addr) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit >= 0) begin
         n = int'(nb_count[hit]);
         if (n < int'(COUNT_MAX)) n++;
         else saturated_count++;
         mean_r = ((n - 1) * int'(nb_rssi[hit]) + int'(rssi)) / n;
         mean_q = ((n - 1) * int'(nb_lqi[hit]) + int'(lqi)) / n;
         nb_count[hit] = COUNT_W'(n);
         nb_rssi[hit]  = SAMPLE_W'(mean_r);
         nb_lqi[hit]   = SAMPLE_W'(mean_q);
         nb_seq[hit]   = seq;
         res.slot      = SLOT_W'(hit);
         res.pkt_count = COUNT_W'(n);
         res.mean_rssi = SAMPLE_W'(mean_r);
         res.mean_lqi  = SAMPLE_W'(mean_q);
         update_count++;
      end else if (free_slot >= 0) begin
         nb_valid[free_slot] = 1'b1;
         nb_addr[free_slot]  = addr;
         nb_count[free_slot] = COUNT_W'(1);
         nb_rssi[free_slot]  = rssi;
         nb_lqi[free_slot]   = lqi;
         nb_seq[free_slot]   = seq;
         res.slot      = SLOT_W'(free_slot);
         res.is_new    = 1'b1;
         res.pkt_count = COUNT_W'(1);
         res.mean_rssi = rssi;
         res.mean_lqi  = lqi;
         entries_used++;
      end else begin
         res.dropped = 1'b1;
         drop_count++;
      end
      return res;
   endfunction

   function automatic bit addr_present(input logic [ADDR_W-1:0] addr);
      for (int i = 0; i < ENTRIES; i++)
         if (nb_valid[i] && nb_addr[i] == addr) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [ADDR_W-1:0] fresh_addr();
      logic [ADDR_W-1:0] addr;
      addr = ADDR_W'($urandom);
      while (addr_present(addr)) addr = ADDR_W'($urandom);
      return addr;
   endfunction

   function automatic logic [ADDR_W-1:0] known_addr();
      int idx;
      idx = $urandom_range(0, entries_used - 1);
      return nb_addr[idx];
   endfunction

   task automatic report_mismatch(input string what, input int got_val, input int exp_val);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch on result %0d: %s is %0d, expected %0d",
                  results_checked, what, got_val, exp_val);
   endtask

   task automatic send_packet(input logic [ADDR_W-1:0] addr,
                              input logic signed [SAMPLE_W-1:0] rssi,
                              input logic [SAMPLE_W-1:0] lqi,
                              input logic [SEQ_W-1:0] seq);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.src_addr <= addr;
      req_bus.rssi     <= rssi;
      req_bus.lqi      <= lqi;
      req_bus.seq_num  <= seq;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(predict_packet(addr, rssi, lqi, seq));
      packets_sent++;
      if (sender_idle) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 4);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic end_phase();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_extremes();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      send_packet(16'h0000, -8'sd128, 8'd0, 8'd0);
      send_packet(16'hFFFF, 8'sd127, 8'd255, 8'd255);
      send_packet(16'h0000, 8'sd127, 8'd255, 8'hAA);
      send_packet(16'hFFFF, -8'sd128, 8'd0, 8'h55);
      send_packet(16'h0000, -8'sd128, 8'd0, 8'd0);
      send_packet(16'hFFFF, 8'sd127, 8'd255, 8'd255);
      send_packet(16'h5A5A, -8'sd1, 8'd1, 8'd1);
      send_packet(16'h5A5A, -8'sd2, 8'd0, 8'd2);
      send_packet(16'hA5A5, 8'sd0, 8'd128, 8'd128);
      send_packet(16'hA5A5, -8'sd128, 8'd255, 8'd127);
      send_packet(16'h8001, -8'sd127, 8'd254, 8'd64);
      send_packet(16'h8001, -8'sd128, 8'd255, 8'd63);
      send_packet(16'h8001, -8'sd128, 8'd255, 8'd62);
      end_phase();
   endtask

   // Sends a long run of packets from the neighbour in slot 0 without gaps or stalls.
   task automatic test_repeated_neighbour();
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      repeat (40)
         send_packet(16'h0000, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SEQ_W'($urandom));
      send_packet(16'h0000, 8'sd127, 8'd255, 8'd1);
      send_packet(16'h0000, -8'sd128, 8'd0, 8'd2);
      send_packet(16'h0000, 8'sd127, 8'd255, 8'd3);
      repeat (5)
         send_packet(16'h0000, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SEQ_W'($urandom));
      end_phase();
   endtask

   task automatic test_mixed_traffic();
      logic [ADDR_W-1:0] addr;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      repeat (420) begin
         if (entries_used < 30 && $urandom_range(0, 4) == 0) addr = fresh_addr();
         else addr = known_addr();
         send_packet(addr, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SEQ_W'($urandom));
      end
      end_phase();
   endtask

   task automatic test_table_full();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      while (entries_used < ENTRIES)
         send_packet(fresh_addr(), SAMPLE_W'($urandom), SAMPLE_W'($urandom), SEQ_W'($urandom));
      send_packet(fresh_addr(), 8'sd127, 8'd255, 8'd255);
      send_packet(fresh_addr(), -8'sd128, 8'd0, 8'd0);
      send_packet(nb_addr[ENTRIES-1], 8'sd5, 8'd5, 8'd5);
      end_phase();
   endtask

   task automatic test_traffic_when_full();
      logic [ADDR_W-1:0] addr;
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      repeat (330) begin
         if ($urandom_range(0, 3) == 0) addr = ADDR_W'($urandom);
         else addr = known_addr();
         send_packet(addr, SAMPLE_W'($urandom), SAMPLE_W'($urandom), SEQ_W'($urandom));
      end
      end_phase();
   endtask

   always @(posedge clock) begin
      link_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("transfer with nothing pending, slot", int'(rsp_bus.slot), 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.slot !== want.slot)
               report_mismatch("slot", int'(rsp_bus.slot), int'(want.slot));
            if (rsp_bus.is_new !== want.is_new)
               report_mismatch("is_new", int'(rsp_bus.is_new), int'(want.is_new));
            if (rsp_bus.dropped !== want.dropped)
               report_mismatch("dropped", int'(rsp_bus.dropped), int'(want.dropped));
            if (rsp_bus.pkt_count !== want.pkt_count)
               report_mismatch("pkt_count", int'(rsp_bus.pkt_count), int'(want.pkt_count));
            if (rsp_bus.mean_rssi !== want.mean_rssi)
               report_mismatch("mean_rssi", int'(rsp_bus.mean_rssi), int'(want.mean_rssi));
            if (rsp_bus.mean_lqi !== want.mean_lqi)
               report_mismatch("mean_lqi", int'(rsp_bus.mean_lqi), int'(want.mean_lqi));
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || !receiver_idle) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= stall_word[stall_phase];
         stall_phase = (stall_phase + 1) % 16;
         if (stall_phase == 0) begin
            case ($urandom_range(0, 5))
               0, 1: stall_word = '1;
               2: stall_word = '0;
               default: stall_word = 16'($urandom);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.src_addr = '0;
      req_bus.rssi     = '0;
      req_bus.lqi      = '0;
      req_bus.seq_num  = '0;
      rsp_bus.ready    = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         nb_valid[i] = 1'b0;
         nb_addr[i]  = '0;
         nb_count[i] = '0;
         nb_rssi[i]  = '0;
         nb_lqi[i]   = '0;
         nb_seq[i]   = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_repeated_neighbour();
      test_mixed_traffic();
      test_table_full();
      test_traffic_when_full();
      $display("%0d packets sent: %0d new neighbours, %0d updates, %0d of them at full count",
               packets_sent, entries_used, update_count, saturated_count);
      $display("%0d packets dropped on a full table, %0d results checked, %0d mismatches",
               drop_count, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
